// File: hdl/qrm_pkg.sv
// ---------------------------------------------------------------------------
// qrm_pkg
// shared types, constants and width helpers for the quaternion to
// rotation matrix unit
// ---------------------------------------------------------------------------
package qrm_pkg;

    // fixed field widths
    localparam int Q_W     = 16;
    localparam int IDX_W   = 4;
    localparam int OUT_W   = 18;
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;

    // last element index for each layout
    localparam logic [IDX_W-1:0] LAST_3X3 = 4'd8;
    localparam logic [IDX_W-1:0] LAST_4X4 = 4'd15;

    // layout register codes
    localparam logic LAYOUT_3X3 = 1'b0;
    localparam logic LAYOUT_4X4 = 1'b1;

    // operand select codes
    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z,
        SEL_W
    } t_sel;

    // per-element product recipe
    typedef struct packed {
        logic zero;   // padding element
        logic unit;   // add 1.0
        t_sel a1;
        t_sel b1;
        logic neg1;
        t_sel a2;
        t_sel b2;
        logic neg2;
    } t_elem_ctl;

    // width of w: holds signed q_w and a derived root up to 1.0
    function automatic int w_width(input int f);
        return (f + 2 > Q_W) ? f + 2 : Q_W;
    endfunction

    // width of an element before rounding
    function automatic int elem_width(input int f);
        return ((2 * f > 32) ? 2 * f : 32) + 4;
    endfunction

    // recipe for output position idx
    function automatic t_elem_ctl elem_ctl(input logic layout, input logic [IDX_W-1:0] idx);
        t_elem_ctl  c;
        logic [3:0] src;
        logic       pad;
        c   = '{zero: 1'b0, unit: 1'b0, a1: SEL_X, b1: SEL_X, neg1: 1'b0,
                a2: SEL_X, b2: SEL_X, neg2: 1'b0};
        pad = 1'b0;
        src = idx;
        if (layout == LAYOUT_4X4) begin
            if (idx == LAST_4X4) begin
                // corner is exactly 1.0, no products
                pad = 1'b1;
                c.zero = 1'b1;
                c.unit = 1'b1;
            end else if (idx[3:2] != 2'd3 && idx[1:0] != 2'd3) begin
                src = 4'(idx[3:2]) * 4'd3 + 4'(idx[1:0]);
            end else begin
                pad = 1'b1;
                c.zero = 1'b1;
            end
        end
        if (!pad) begin
            case (src)
                4'd0: begin
                    c.unit = 1'b1;
                    c.a1 = SEL_Y; c.b1 = SEL_Y; c.neg1 = 1'b1;
                    c.a2 = SEL_Z; c.b2 = SEL_Z; c.neg2 = 1'b1;
                end
                4'd1: begin
                    c.a1 = SEL_X; c.b1 = SEL_Y; c.neg1 = 1'b0;
                    c.a2 = SEL_Z; c.b2 = SEL_W; c.neg2 = 1'b1;
                end
                4'd2: begin
                    c.a1 = SEL_X; c.b1 = SEL_Z; c.neg1 = 1'b0;
                    c.a2 = SEL_Y; c.b2 = SEL_W; c.neg2 = 1'b0;
                end
                4'd3: begin
                    c.a1 = SEL_X; c.b1 = SEL_Y; c.neg1 = 1'b0;
                    c.a2 = SEL_Z; c.b2 = SEL_W; c.neg2 = 1'b0;
                end
                4'd4: begin
                    c.unit = 1'b1;
                    c.a1 = SEL_X; c.b1 = SEL_X; c.neg1 = 1'b1;
                    c.a2 = SEL_Z; c.b2 = SEL_Z; c.neg2 = 1'b1;
                end
                4'd5: begin
                    c.a1 = SEL_Y; c.b1 = SEL_Z; c.neg1 = 1'b0;
                    c.a2 = SEL_X; c.b2 = SEL_W; c.neg2 = 1'b1;
                end
                4'd6: begin
                    c.a1 = SEL_X; c.b1 = SEL_Z; c.neg1 = 1'b0;
                    c.a2 = SEL_Y; c.b2 = SEL_W; c.neg2 = 1'b1;
                end
                4'd7: begin
                    c.a1 = SEL_Y; c.b1 = SEL_Z; c.neg1 = 1'b0;
                    c.a2 = SEL_X; c.b2 = SEL_W; c.neg2 = 1'b0;
                end
                4'd8: begin
                    c.unit = 1'b1;
                    c.a1 = SEL_X; c.b1 = SEL_X; c.neg1 = 1'b1;
                    c.a2 = SEL_Y; c.b2 = SEL_Y; c.neg2 = 1'b1;
                end
                default: begin
                    c.zero = 1'b1;
                end
            endcase
        end
        return c;
    endfunction

endpackage

// File: hdl/qrm_isqrt.sv
// ---------------------------------------------------------------------------
// qrm_isqrt
// iterative integer square root, one result bit per cycle
// ---------------------------------------------------------------------------
module qrm_isqrt #(
    parameter int FRAC_BITS = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [2*FRAC_BITS+1:0] i_radicand,
    output logic                   o_done,
    output logic [FRAC_BITS:0]     o_root
);
    localparam int N    = FRAC_BITS + 1;
    localparam int RADW = 2 * N;
    localparam int REMW = N + 2;
    localparam int SHW  = N + 4;
    localparam int CW   = $clog2(N + 1);

    logic            r_run;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [RADW-1:0] r_rad;
    logic [REMW-1:0] r_rem;
    logic [N-1:0]    r_root;

    logic [SHW-1:0]  rem_sh;
    logic [SHW-1:0]  trial;
    logic            fits;
    logic [REMW-1:0] n_rem;
    logic [N-1:0]    n_root;

    // one restoring step on the next two radicand bits
    always_comb begin
        rem_sh = {r_rem, r_rad[RADW-1 -: 2]};
        trial  = SHW'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
        n_rem  = fits ? REMW'(rem_sh - trial) : REMW'(rem_sh);
        n_root = {r_root[N-2:0], fits};
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= CW'(N);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_run) begin
                r_rad  <= {r_rad[RADW-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: hdl/qrm_front.sv
// ---------------------------------------------------------------------------
// qrm_front
// accepts words, passes w through or derives it by square root, and
// pushes the completed operand set into the queue
// ---------------------------------------------------------------------------
module qrm_front #(
    parameter int FRAC_BITS = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [15:0]       i_q_x,
    input  logic signed [15:0]       i_q_y,
    input  logic signed [15:0]       i_q_z,
    input  logic signed [15:0]       i_q_w,
    input  logic                     i_has_w,
    input  logic                     i_full,
    output logic                     o_push,
    output logic [3*qrm_pkg::Q_W+qrm_pkg::w_width(FRAC_BITS)-1:0] o_data
);
    import qrm_pkg::*;

    localparam int WW   = w_width(FRAC_BITS);
    localparam int EW   = elem_width(FRAC_BITS);
    localparam int N    = FRAC_BITS + 1;
    localparam int RADW = 2 * N;
    localparam logic signed [EW-1:0] ONE_E = EW'(1) <<< (2 * FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_RAD,
        S_ROOT,
        S_PUSH
    } t_state;

    t_state                 r_state;
    logic signed [Q_W-1:0]  r_x;
    logic signed [Q_W-1:0]  r_y;
    logic signed [Q_W-1:0]  r_z;
    logic signed [WW-1:0]   r_w;
    logic signed [31:0]     r_sq_x;
    logic signed [31:0]     r_sq_y;
    logic signed [31:0]     r_sq_z;

    logic                   accept;
    logic signed [EW-1:0]   rad;
    logic [RADW-1:0]        rad_pos;
    logic                   sq_start;
    logic                   sq_done;
    logic [N-1:0]           sq_root;

    // handshake
    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_busy = !((r_state == S_IDLE) || o_push);
    assign accept = i_start && !o_busy;
    assign o_data = {r_x, r_y, r_z, r_w};

    // radicand 1 - x^2 - y^2 - z^2, clamped at zero
    always_comb begin
        rad     = ONE_E - EW'(r_sq_x) - EW'(r_sq_y) - EW'(r_sq_z);
        rad_pos = (rad > 0) ? RADW'(rad) : '0;
    end
    assign sq_start = (r_state == S_RAD);

    qrm_isqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (rad_pos),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // state and operand registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE, S_PUSH: begin
                    if (accept) begin
                        r_x <= i_q_x;
                        r_y <= i_q_y;
                        r_z <= i_q_z;
                        r_w <= WW'(i_q_w);
                        r_state <= i_has_w ? S_PUSH : S_SQUARE;
                    end else if (o_push) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SQUARE: begin
                    r_sq_x  <= r_x * r_x;
                    r_sq_y  <= r_y * r_y;
                    r_sq_z  <= r_z * r_z;
                    r_state <= S_RAD;
                end
                S_RAD: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (sq_done) begin
                        r_w     <= WW'(sq_root);
                        r_state <= S_PUSH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/qrm_fifo.sv
// ---------------------------------------------------------------------------
// qrm_fifo
// two-entry queue between the front and back parts
// ---------------------------------------------------------------------------
module qrm_fifo #(
    parameter int DATA_W = 66
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);
    localparam int DEPTH = 2;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;

    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/qrm_back.sv
// ---------------------------------------------------------------------------
// qrm_back
// walks the matrix positions of one operand set, one element per cycle:
// products, sum, then rounding and saturation
// ---------------------------------------------------------------------------
module qrm_back #(
    parameter int FRAC_BITS = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_layout,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  logic [3*qrm_pkg::Q_W+qrm_pkg::w_width(FRAC_BITS)-1:0] i_data,
    output logic                   o_valid,
    output logic [qrm_pkg::IDX_W-1:0]        o_element_index,
    output logic signed [qrm_pkg::OUT_W-1:0] o_element_value,
    output logic                   o_last
);
    import qrm_pkg::*;

    localparam int WW  = w_width(FRAC_BITS);
    localparam int EW  = elem_width(FRAC_BITS);
    localparam int P2W = Q_W + WW;
    localparam int QW  = EW - FRAC_BITS;
    localparam logic signed [EW-1:0] ONE_E  = EW'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [EW-1:0] HALF_E = EW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [QW-1:0] SAT_HI = QW'(OUT_MAX);
    localparam logic signed [QW-1:0] SAT_LO = QW'(OUT_MIN);

    // current operand set
    logic                   r_act;
    logic [IDX_W-1:0]       r_idx;
    logic signed [Q_W-1:0]  r_x;
    logic signed [Q_W-1:0]  r_y;
    logic signed [Q_W-1:0]  r_z;
    logic signed [WW-1:0]   r_w;

    // product stage
    logic                   r_s1_vld;
    logic [IDX_W-1:0]       r_s1_idx;
    logic                   r_s1_last;
    t_elem_ctl              r_s1_ctl;
    logic signed [31:0]     r_p1;
    logic signed [P2W-1:0]  r_p2;

    // sum stage
    logic                   r_s2_vld;
    logic [IDX_W-1:0]       r_s2_idx;
    logic                   r_s2_last;
    logic signed [EW-1:0]   r_s2_sum;

    // output stage
    logic                   r_out_vld;
    logic [IDX_W-1:0]       r_out_idx;
    logic                   r_out_last;
    logic signed [OUT_W-1:0] r_out_val;

    t_elem_ctl              ctl;
    logic                   issue_last;
    logic signed [Q_W-1:0]  op_a1;
    logic signed [Q_W-1:0]  op_b1;
    logic signed [Q_W-1:0]  op_a2;
    logic signed [WW-1:0]   op_b2;
    logic signed [EW-1:0]   t1;
    logic signed [EW-1:0]   t2;
    logic signed [EW-1:0]   n_sum;
    logic signed [EW-1:0]   rnd;
    logic signed [QW-1:0]   q;
    logic signed [OUT_W-1:0] n_val;

    function automatic logic signed [Q_W-1:0] pick16(input t_sel s,
            input logic signed [Q_W-1:0] x, input logic signed [Q_W-1:0] y,
            input logic signed [Q_W-1:0] z);
        case (s)
            SEL_Y:   return y;
            SEL_Z:   return z;
            default: return x;
        endcase
    endfunction

    // element recipe and operand selection
    always_comb begin
        ctl        = elem_ctl(i_layout, r_idx);
        issue_last = (i_layout == LAYOUT_4X4) ? (r_idx == LAST_4X4) : (r_idx == LAST_3X3);
        op_a1      = pick16(ctl.a1, r_x, r_y, r_z);
        op_b1      = pick16(ctl.b1, r_x, r_y, r_z);
        op_a2      = pick16(ctl.a2, r_x, r_y, r_z);
        case (ctl.b2)
            SEL_Y:   op_b2 = WW'(r_y);
            SEL_Z:   op_b2 = WW'(r_z);
            SEL_W:   op_b2 = r_w;
            default: op_b2 = WW'(r_x);
        endcase
    end

    // take the next operand set when idle or on the last position of the current one
    assign o_pop = !i_empty && (!r_act || issue_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
                {r_x, r_y, r_z, r_w} <= i_data;
            end else if (r_act) begin
                if (issue_last) begin
                    r_act <= 1'b0;
                end
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_act;
        end
        r_s1_idx  <= r_idx;
        r_s1_last <= issue_last;
        r_s1_ctl  <= ctl;
        r_p1      <= op_a1 * op_b1;
        r_p2      <= op_a2 * op_b2;
    end

    // sum: base plus or minus twice each product
    always_comb begin
        t1    = EW'(r_p1) <<< 1;
        t2    = EW'(r_p2) <<< 1;
        if (r_s1_ctl.neg1) begin
            t1 = -t1;
        end
        if (r_s1_ctl.neg2) begin
            t2 = -t2;
        end
        n_sum = (r_s1_ctl.unit ? ONE_E : '0) + t1 + t2;
        if (r_s1_ctl.zero) begin
            n_sum = r_s1_ctl.unit ? ONE_E : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_idx  <= r_s1_idx;
        r_s2_last <= r_s1_last;
        r_s2_sum  <= n_sum;
    end

    // round to nearest with ties up, then saturate
    always_comb begin
        rnd = r_s2_sum + HALF_E;
        q   = QW'(rnd >>> FRAC_BITS);
        if (q > SAT_HI) begin
            n_val = OUT_W'(SAT_HI);
        end else if (q < SAT_LO) begin
            n_val = OUT_W'(SAT_LO);
        end else begin
            n_val = OUT_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s2_vld;
        end
        r_out_idx  <= r_s2_idx;
        r_out_last <= r_s2_last;
        r_out_val  <= n_val;
    end

    assign o_valid         = r_out_vld;
    assign o_element_index = r_out_idx;
    assign o_element_value = r_out_val;
    assign o_last          = r_out_last;

endmodule

// File: hdl/quaternion_to_rotation_matrix_unit.sv
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// converts a quaternion into its rotation matrix, streamed one element
// per cycle in row order as a 3x3 or 4x4 homogeneous matrix
// ---------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  input     | start / busy           | i_q_x, i_q_y, i_q_z, i_q_w, i_has_w
//  config    | i_cfg_wr_en            | i_cfg_wr_data (matrix layout)
//  result    | o_valid, one cycle     | o_element_index, o_element_value, o_last
//
//  the back part emits one element per cycle: 9 elements per word in 3x3
//  layout, 16 in 4x4, back to back across words while the queue is not empty.
//  a word with has_w set goes straight to the push state on acceptance;
//  one without it first passes the square, radicand and root states, the
//  root coming from the bit-per-cycle square root.
//  a two-entry queue sits between front and back; each element then passes
//  the product, sum and output stages, all registered.
//  synchronous active-low reset clears all control state.
//  results cannot be held off; busy is high while the front is deriving w
//  and while it holds a finished word that the full queue cannot take.
// ---------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit #(
    parameter int FRAC_BITS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qrm_pkg::Q_W-1:0]      i_q_x,
    input  logic signed [qrm_pkg::Q_W-1:0]      i_q_y,
    input  logic signed [qrm_pkg::Q_W-1:0]      i_q_z,
    input  logic signed [qrm_pkg::Q_W-1:0]      i_q_w,
    input  logic                                i_has_w,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    output logic                                o_valid,
    output logic [qrm_pkg::IDX_W-1:0]           o_element_index,
    output logic signed [qrm_pkg::OUT_W-1:0]    o_element_value,
    output logic                                o_last
);
    import qrm_pkg::*;

    localparam int DW = 3 * Q_W + w_width(FRAC_BITS);

    logic          r_layout;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    logic [DW-1:0] q_wdata;
    logic [DW-1:0] q_rdata;

    // layout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= LAYOUT_3X3;
        end else if (i_cfg_wr_en) begin
            r_layout <= i_cfg_wr_data;
        end
    end

    qrm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_q_x   (i_q_x),
        .i_q_y   (i_q_y),
        .i_q_z   (i_q_z),
        .i_q_w   (i_q_w),
        .i_has_w (i_has_w),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_data  (q_wdata)
    );

    qrm_fifo #(
        .DATA_W (DW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    qrm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_layout        (r_layout),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .i_data          (q_rdata),
        .o_valid         (o_valid),
        .o_element_index (o_element_index),
        .o_element_value (o_element_value),
        .o_last          (o_last)
    );

endmodule

// File: hdl/qrm_checker.sv
// ---------------------------------------------------------------------------
// qrm_checker
// port-level checks on the element stream of the rotation matrix unit
// ---------------------------------------------------------------------------
module qrm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                busy,
    input logic                                o_valid,
    input logic [qrm_pkg::IDX_W-1:0]           o_element_index,
    input logic signed [qrm_pkg::OUT_W-1:0]    o_element_value,
    input logic                                o_last
);
    import qrm_pkg::*;

    // a matrix ends only on its final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_element_index == LAST_3X3 ||
                                 o_element_index == LAST_4X4))
        else $error("last flag on wrong element");

    // elements of one matrix follow with no gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid &&
            o_element_index == $past(o_element_index) + IDX_W'(1)))
        else $error("gap or skip inside a matrix");

    // a new matrix starts at position zero
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (!$past(o_valid) || $past(o_last))) |-> (o_element_index == '0))
        else $error("matrix does not start at position zero");

    // bottom padding row is zero apart from the corner
    a_pad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_element_index == 4'd12 || o_element_index == 4'd13 ||
                     o_element_index == 4'd14)) |-> (o_element_value == '0))
        else $error("nonzero padding element");

    // the front is free right after reset
    a_reset_free: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !busy)
        else $error("busy after reset");

endmodule

bind quaternion_to_rotation_matrix_unit qrm_checker u_qrm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_element_index (o_element_index),
    .o_element_value (o_element_value),
    .o_last          (o_last)
);
